/* design/hsvled_pkg.sv */
// ----------------------------------------------------------------------------
// hsvled_pkg : shared types and constants for the HSV to RGB LED drive core
// Fixed-point widths, reciprocal constants, sector codes and the stage
// payload structs.
// ----------------------------------------------------------------------------
package hsvled_pkg;

  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int DRV_W  = 8;
  localparam int FRAC_W = 16;

  localparam int S_W = FRAC_W + 1;  // 0..65536
  localparam int V_W = FRAC_W;      // 0..32768
  localparam int U_W = FRAC_W + 1;  // 0..129979
  localparam int C_W = FRAC_W;      // 0..32768

  localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(359);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // floor(n*65536/100) = (n*RECIP_PCT) >> 16 for n <= 100
  localparam int RECIP_PCT_W = 26;
  localparam logic [RECIP_PCT_W-1:0] RECIP_PCT = RECIP_PCT_W'(42949673);
  // floor(n*65536/60) = (n*RECIP_HUE) >> 16 for n < 120
  localparam int RECIP_HUE_W = 27;
  localparam logic [RECIP_HUE_W-1:0] RECIP_HUE = RECIP_HUE_W'(71582789);

  localparam int HM_W = 7;  // hue mod 120

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic [V_W-1:0] v;
    logic [U_W-1:0] u;
    sector_t        sector;
  } prep_t;

  typedef struct packed {
    logic [C_W-1:0] c;
    logic [V_W-1:0] v;
    logic [U_W-1:0] w;
    sector_t        sector;
  } chroma_t;

  typedef struct packed {
    logic [C_W-1:0] c;
    logic [C_W-1:0] x;
    logic [V_W-1:0] m;
    sector_t        sector;
  } comp_t;

  typedef struct packed {
    logic [DRV_W-1:0] blue_drive;
    logic [DRV_W-1:0] green_drive;
    logic [DRV_W-1:0] red_drive;
  } drive_t;

  function automatic logic [S_W-1:0] pct_to_frac(input logic [PCT_W-1:0] pct);
    logic [PCT_W+RECIP_PCT_W-1:0] prod;
    prod = {{RECIP_PCT_W{1'b0}}, pct} * {{PCT_W{1'b0}}, RECIP_PCT};
    return prod[FRAC_W +: S_W];
  endfunction

endpackage

/* design/hsvled_prep.sv */
// ----------------------------------------------------------------------------
// hsvled_prep : input saturation and fraction lookup
// Clamps the inputs, forms s, v, the hue ramp u and the 60-degree sector.
// ----------------------------------------------------------------------------
module hsvled_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsvled_pkg::HUE_W-1:0]  hue_degrees,
  input  logic [hsvled_pkg::PCT_W-1:0]  saturation_pct,
  input  logic [hsvled_pkg::PCT_W-1:0]  value_pct,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hsvled_pkg::prep_t             out_data
);
  import hsvled_pkg::*;

  logic [HUE_W-1:0]                 h;
  logic [PCT_W-1:0]                 sp;
  logic [PCT_W-1:0]                 vp;
  logic [HM_W-1:0]                  hm;
  logic [S_W-1:0]                   v_full;
  logic [HM_W+RECIP_HUE_W-1:0]      u_prod;
  sector_t                          sector;
  prep_t                            data_next;

  assign h  = (hue_degrees > HUE_MAX) ? HUE_MAX : hue_degrees;
  assign sp = (saturation_pct > PCT_MAX) ? PCT_MAX : saturation_pct;
  assign vp = (value_pct > PCT_MAX) ? PCT_MAX : value_pct;

  always_comb begin
    if (h >= HUE_W'(240)) begin
      hm = HM_W'(h - HUE_W'(240));
    end else if (h >= HUE_W'(120)) begin
      hm = HM_W'(h - HUE_W'(120));
    end else begin
      hm = HM_W'(h);
    end
  end

  always_comb begin
    if (h >= HUE_W'(300)) begin
      sector = SEC_MAG_RED;
    end else if (h >= HUE_W'(240)) begin
      sector = SEC_BLU_MAG;
    end else if (h >= HUE_W'(180)) begin
      sector = SEC_CYN_BLU;
    end else if (h >= HUE_W'(120)) begin
      sector = SEC_GRN_CYN;
    end else if (h >= HUE_W'(60)) begin
      sector = SEC_YEL_GRN;
    end else begin
      sector = SEC_RED_YEL;
    end
  end

  assign u_prod      = {{RECIP_HUE_W{1'b0}}, hm} * {{HM_W{1'b0}}, RECIP_HUE};
  assign v_full      = pct_to_frac(vp);
  assign data_next.s = pct_to_frac(sp);
  // V/200 is the percent fraction halved
  assign data_next.v = v_full[S_W-1:1];
  assign data_next.u = u_prod[FRAC_W +: U_W];
  assign data_next.sector = sector;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* design/hsvled_chroma.sv */
// ----------------------------------------------------------------------------
// hsvled_chroma : chroma product and hue weight
// C = s*v, and the triangle weight 1-|u-1| from the hue ramp.
// ----------------------------------------------------------------------------
module hsvled_chroma (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvled_pkg::prep_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvled_pkg::chroma_t out_data
);
  import hsvled_pkg::*;

  logic [S_W+V_W-1:0] sv_prod;
  chroma_t            data_next;

  assign sv_prod = {{V_W{1'b0}}, in_data.s} * {{S_W{1'b0}}, in_data.v};

  always_comb begin
    data_next.c      = sv_prod[FRAC_W +: C_W];
    data_next.v      = in_data.v;
    data_next.sector = in_data.sector;
    if (in_data.u[U_W-1]) begin
      data_next.w = U_W'((U_W+1)'(2) * (U_W+1)'(1 << FRAC_W) - (U_W+1)'(in_data.u));
    end else begin
      data_next.w = in_data.u;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* design/hsvled_second.sv */
// ----------------------------------------------------------------------------
// hsvled_second : second component and offset
// X = C*w, m = v-C.
// ----------------------------------------------------------------------------
module hsvled_second (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsvled_pkg::chroma_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsvled_pkg::comp_t   out_data
);
  import hsvled_pkg::*;

  logic [C_W+U_W-1:0] cw_prod;
  comp_t              data_next;

  assign cw_prod = {{U_W{1'b0}}, in_data.c} * {{C_W{1'b0}}, in_data.w};

  assign data_next.c      = in_data.c;
  assign data_next.x      = cw_prod[FRAC_W +: C_W];
  assign data_next.m      = in_data.v - in_data.c;
  assign data_next.sector = in_data.sector;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* design/hsvled_mix.sv */
// ----------------------------------------------------------------------------
// hsvled_mix : channel placement and drive levels
// Places C and X by sector, adds m, scales by 255 and inverts for the
// active-low drivers. Holds the output register.
// ----------------------------------------------------------------------------
module hsvled_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvled_pkg::comp_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvled_pkg::drive_t out_data
);
  import hsvled_pkg::*;

  localparam int LVL_PROD_W = V_W + DRV_W;

  logic [C_W-1:0] r;
  logic [C_W-1:0] g;
  logic [C_W-1:0] b;
  drive_t         data_next;

  function automatic logic [DRV_W-1:0] drive_of(input logic [V_W-1:0] lvl);
    logic [LVL_PROD_W-1:0] prod;
    // lvl*255 as lvl*256 - lvl
    prod = {lvl, {DRV_W{1'b0}}} - LVL_PROD_W'(lvl);
    return DRV_W'(255) - prod[FRAC_W +: DRV_W];
  endfunction

  always_comb begin
    case (in_data.sector)
      SEC_RED_YEL: begin r = in_data.c; g = in_data.x; b = '0;        end
      SEC_YEL_GRN: begin r = in_data.x; g = in_data.c; b = '0;        end
      SEC_GRN_CYN: begin r = '0;        g = in_data.c; b = in_data.x; end
      SEC_CYN_BLU: begin r = '0;        g = in_data.x; b = in_data.c; end
      SEC_BLU_MAG: begin r = in_data.x; g = '0;        b = in_data.c; end
      default:     begin r = in_data.c; g = '0;        b = in_data.x; end
    endcase
  end

  assign data_next.red_drive   = drive_of(r + in_data.m);
  assign data_next.green_drive = drive_of(g + in_data.m);
  assign data_next.blue_drive  = drive_of(b + in_data.m);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* design/hsv_to_rgb_led_drive_core.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_drive_core : HSV colour to active-low RGB PWM duties
//
//   bus      dir  beat
//   s_axis   in   one HSV colour (hue, saturation, value)
//   m_axis   out  three active-low duty bytes (red, green, blue)
//
// One colour per clock while m_axis is not stalled; four register stages
// (prepare, chroma multiply, second-component multiply, mix).
// Each stage holds its own valid bit and stalls only when full and blocked,
// so bubbles close up behind a stalled output.
// Reset clears the valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_drive_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hue_degrees[8:0], saturation_pct[15:9],
                                      // value_pct[22:16], zero[23]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red_drive[7:0], green_drive[15:8],
                                      // blue_drive[23:16]
);
  import hsvled_pkg::*;

  logic    prep_valid;
  logic    prep_ready;
  prep_t   prep_data;
  logic    chroma_valid;
  logic    chroma_ready;
  chroma_t chroma_data;
  logic    comp_valid;
  logic    comp_ready;
  comp_t   comp_data;
  drive_t  drive_data;

  hsvled_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .hue_degrees    (s_axis_tdata[HUE_W-1:0]),
    .saturation_pct (s_axis_tdata[HUE_W +: PCT_W]),
    .value_pct      (s_axis_tdata[HUE_W+PCT_W +: PCT_W]),
    .out_valid      (prep_valid),
    .out_ready      (prep_ready),
    .out_data       (prep_data)
  );

  hsvled_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (chroma_valid),
    .out_ready (chroma_ready),
    .out_data  (chroma_data)
  );

  hsvled_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chroma_valid),
    .in_ready  (chroma_ready),
    .in_data   (chroma_data),
    .out_valid (comp_valid),
    .out_ready (comp_ready),
    .out_data  (comp_data)
  );

  hsvled_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (comp_valid),
    .in_ready  (comp_ready),
    .in_data   (comp_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (drive_data)
  );

  assign m_axis_tdata = drive_data;

endmodule

/* sim/hsv_to_rgb_led_drive_core_tb.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_drive_core_tb : colour-conversion check of the LED drive core
// The test first sends a short table of edge colours: sector borders, black,
// grey, pure primaries and over-range hue, saturation and value. It then
// sends random colours under several idle and stall mixes. Every output beat
// is compared field by field with its expected drives: fixed values for the
// first table rows, else an in-bench fixed-point HSV to RGB calculation.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_drive_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvled_pkg::*;

  localparam int          RANDOM_PER_PHASE = 300;
  localparam int          NUM_PHASES       = 5;
  localparam int          CYCLE_LIMIT      = 400000;
  localparam logic [63:0] FRAC_ONE         = 64'd65536;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    bit               fixed;
    drive_t           want;
  } colour_row_t;

  localparam drive_t DRIVE_OFF   = '{red_drive: 8'd255, green_drive: 8'd255, blue_drive: 8'd255};
  localparam drive_t DRIVE_RED   = '{red_drive: 8'd128, green_drive: 8'd255, blue_drive: 8'd255};
  localparam drive_t DRIVE_GREEN = '{red_drive: 8'd255, green_drive: 8'd128, blue_drive: 8'd255};
  localparam drive_t DRIVE_BLUE  = '{red_drive: 8'd255, green_drive: 8'd255, blue_drive: 8'd128};
  localparam drive_t DRIVE_GREY  = '{red_drive: 8'd128, green_drive: 8'd128, blue_drive: 8'd128};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  drive_t      pending_drives[$];
  int          errors  = 0;
  int          checked = 0;
  int          sent    = 0;
  int          cycles  = 0;
  int          idle_pct  = 0;
  int          stall_pct = 0;

  colour_row_t edge_rows[23];

  hsv_to_rgb_led_drive_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic drive_t hsv_to_drive(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                          logic [PCT_W-1:0] val);
    logic [HUE_W-1:0] h;
    logic [PCT_W-1:0] sp;
    logic [PCT_W-1:0] vp;
    logic [63:0]      s, v, c, u, d, x, m, r, g, b;
    sector_t          sec;
    drive_t           res;
    h  = (hue > HUE_MAX) ? HUE_MAX : hue;
    sp = (sat > PCT_MAX) ? PCT_MAX : sat;
    vp = (val > PCT_MAX) ? PCT_MAX : val;
    s  = 64'(sp) * FRAC_ONE / 64'd100;
    v  = 64'(vp) * FRAC_ONE / 64'd200;
    c  = s * v / FRAC_ONE;
    u  = 64'(h % 9'd120) * FRAC_ONE / 64'd60;
    d  = (u >= FRAC_ONE) ? (u - FRAC_ONE) : (FRAC_ONE - u);
    x  = c * (FRAC_ONE - d) / FRAC_ONE;
    m  = v - c;
    sec = sector_t'(h / 9'd60);
    case (sec)
      SEC_RED_YEL: begin r = c; g = x; b = 0; end
      SEC_YEL_GRN: begin r = x; g = c; b = 0; end
      SEC_GRN_CYN: begin r = 0; g = c; b = x; end
      SEC_CYN_BLU: begin r = 0; g = x; b = c; end
      SEC_BLU_MAG: begin r = x; g = 0; b = c; end
      default:     begin r = c; g = 0; b = x; end
    endcase
    res.red_drive   = 8'd255 - 8'((r + m) * 64'd255 / FRAC_ONE);
    res.green_drive = 8'd255 - 8'((g + m) * 64'd255 / FRAC_ONE);
    res.blue_drive  = 8'd255 - 8'((b + m) * 64'd255 / FRAC_ONE);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // one colour beat; expectation queued as soon as the beat is offered
  task automatic send_colour(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                             logic [PCT_W-1:0] val, bit fixed, drive_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, sat, hue};
    pending_drives.push_back(fixed ? want : hsv_to_drive(hue, sat, val));
    sent++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = drive_t'(m_axis_tdata);
      if (pending_drives.size() == 0) begin
        report_mismatch("unexpected beat", int'(m_axis_tdata), -1);
      end else begin
        want = pending_drives.pop_front();
        checked++;
        if (got.red_drive !== want.red_drive)
          report_mismatch("red_drive", got.red_drive, want.red_drive);
        if (got.green_drive !== want.green_drive)
          report_mismatch("green_drive", got.green_drive, want.green_drive);
        if (got.blue_drive !== want.blue_drive)
          report_mismatch("blue_drive", got.blue_drive, want.blue_drive);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d beats outstanding", $realtime, pending_drives.size());
      $display("hsv_to_rgb_led_drive_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int idle_tab[NUM_PHASES];
    int stall_tab[NUM_PHASES];
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;

    idle_tab  = '{0, 46, 0, 36, 0};
    stall_tab = '{0, 0, 46, 36, 0};

    edge_rows = '{
      '{9'd0,   7'd0,   7'd0,   1'b1, DRIVE_OFF},
      '{9'd0,   7'd100, 7'd100, 1'b1, DRIVE_RED},
      '{9'd120, 7'd100, 7'd100, 1'b1, DRIVE_GREEN},
      '{9'd240, 7'd100, 7'd100, 1'b1, DRIVE_BLUE},
      '{9'd0,   7'd0,   7'd100, 1'b1, DRIVE_GREY},
      '{9'd511, 7'd127, 7'd0,   1'b1, DRIVE_OFF},
      '{9'd0,   7'd127, 7'd127, 1'b1, DRIVE_RED},
      '{9'd59,  7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd60,  7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd119, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd179, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd180, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd239, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd299, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd300, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd359, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd360, 7'd100, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd511, 7'd127, 7'd127, 1'b0, DRIVE_OFF},
      '{9'd30,  7'd50,  7'd50,  1'b0, DRIVE_OFF},
      '{9'd90,  7'd101, 7'd100, 1'b0, DRIVE_OFF},
      '{9'd200, 7'd100, 7'd101, 1'b0, DRIVE_OFF},
      '{9'd330, 7'd1,   7'd1,   1'b0, DRIVE_OFF},
      '{9'd256, 7'd85,  7'd42,  1'b0, DRIVE_OFF}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_rows[i])
      send_colour(edge_rows[i].hue, edge_rows[i].sat, edge_rows[i].val,
                  edge_rows[i].fixed, edge_rows[i].want);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) begin
          hue = HUE_W'($urandom_range(359));
          sat = PCT_W'($urandom_range(100));
          val = PCT_W'($urandom_range(100));
        end else begin
          hue = HUE_W'($urandom_range(511));
          sat = PCT_W'($urandom_range(127));
          val = PCT_W'($urandom_range(127));
        end
        send_colour(hue, sat, val, 1'b0, DRIVE_OFF);
        // hold off now and then until the pipe is empty
        if (n % 97 == 96)
          drain_results();
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (12) @(posedge clk);
    if (pending_drives.size() != 0)
      report_mismatch("beats never delivered", 0, pending_drives.size());

    $display("sent %0d colours (edge table plus random), %0d output beats checked",
             sent, checked);
    $display("idle/stall mixes: none, sender 46%%, receiver 46%%, both 36%%, none with drains");
    if (errors == 0) begin
      $display("hsv_to_rgb_led_drive_core_tb: PASS");
    end else begin
      $display("hsv_to_rgb_led_drive_core_tb: FAIL");
    end
    $finish;
  end

endmodule
